// ===== hdl/bcs_pkg.sv =====
package bcs_pkg;

  // Sizes
  localparam int MAX_POINTS  = 16;
  localparam int MAX_SAMPLES = 64;
  localparam int PT_IDX_W    = $clog2(MAX_POINTS);
  localparam int PT_CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SMP_W       = 7;
  localparam int J_W         = $clog2(MAX_SAMPLES);
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 30;
  localparam int NUM_W       = J_W + FRAC_W;
  localparam int REM_W       = J_W + 1;
  localparam int WGT_W       = 32;
  localparam int T_W         = FRAC_W + 1;
  localparam int MUL_W       = 34;
  localparam int PROD_W      = 64;
  localparam int ACC_W       = 40;
  localparam int DCNT_W      = $clog2(NUM_W + 1);

  localparam logic [T_W-1:0]    ONE_Q30  = T_W'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] HALF_Q30 = PROD_W'(1) << (FRAC_W - 1);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_DIV_STEP,
    OP_W_MUL_U,
    OP_W_MUL_T,
    OP_W_WRITE,
    OP_RD,
    OP_MUL_X,
    OP_MUL_Y,
    OP_ADD_Y,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [PT_IDX_W-1:0] idx;
    logic                i_lt_d;
    logic                i_gt0;
    logic [J_W-1:0]      j;
    logic [J_W-1:0]      den;
    logic                final_smp;
    logic                trunc;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_W_MU,
    ST_W_MT,
    ST_W_WR,
    ST_RD,
    ST_MX,
    ST_MY,
    ST_AY,
    ST_EMIT
  } ctrl_state_t;

endpackage

// ===== hdl/bcs_if.sv =====
interface bcs_in_if import bcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] ctrl_x;
  logic signed [COORD_W-1:0] ctrl_y;
  logic                      set_end;

  modport source (output valid, ctrl_x, ctrl_y, set_end, input ready);
  modport sink   (input valid, ctrl_x, ctrl_y, set_end, output ready);
endinterface

interface bcs_out_if import bcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic                      final_sample;
  logic                      truncated;

  modport source (output valid, curve_x, curve_y, final_sample, truncated, input ready);
  modport sink   (input valid, curve_x, curve_y, final_sample, truncated, output ready);
endinterface

// ===== hdl/bcs_ram.sv =====
module bcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

// ===== hdl/bcs_dp.sv =====
module bcs_dp import bcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  bcs_out_if.source                 out_ch,
  output dp_stat_t                  stat
);
  logic [2*COORD_W-1:0]      ram_rdata;
  logic [NUM_W-1:0]          num_r;
  logic [REM_W-1:0]          rem_r;
  logic [WGT_W-1:0]          w_r [MAX_POINTS];
  logic [WGT_W-1:0]          prev_r;
  logic [PROD_W-1:0]         wacc_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   ax_r;
  logic signed [ACC_W-1:0]   ay_r;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic                      out_final_r;
  logic                      out_trunc_r;

  logic [T_W-1:0]            t_val;
  logic [T_W-1:0]            u_val;
  logic signed [MUL_W-1:0]   ma;
  logic signed [MUL_W-1:0]   mb;
  logic signed [2*MUL_W-1:0] prod_full;
  logic [REM_W-1:0]          rem_sh;
  logic                      q_bit;
  logic [PROD_W-1:0]         wsum;
  logic signed [PROD_W-1:0]  term_full;
  logic signed [ACC_W-1:0]   term;
  logic signed [COORD_W-1:0] sat_x;
  logic signed [COORD_W-1:0] sat_y;

  // Point store: x in the upper half, y in the lower
  bcs_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (cmd.op == OP_LOAD),
    .waddr (cmd.idx),
    .wdata ({in_x, in_y}),
    .re    (cmd.op == OP_RD),
    .raddr (cmd.idx),
    .rdata (ram_rdata)
  );

  assign t_val = num_r[T_W-1:0];
  assign u_val = ONE_Q30 - t_val;

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_W_MUL_U: begin
        ma = cmd.i_lt_d ? MUL_W'(u_val) : '0;
        mb = MUL_W'(w_r[cmd.idx]);
      end
      OP_W_MUL_T: begin
        ma = cmd.i_gt0 ? MUL_W'(t_val) : '0;
        mb = MUL_W'(prev_r);
      end
      OP_MUL_X: begin
        ma = MUL_W'(w_r[cmd.idx]);
        mb = MUL_W'(signed'(ram_rdata[2*COORD_W-1:COORD_W]));
      end
      OP_MUL_Y: begin
        ma = MUL_W'(w_r[cmd.idx]);
        mb = MUL_W'(signed'(ram_rdata[COORD_W-1:0]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_full = ma * mb;

  // Restoring divide step
  assign rem_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign q_bit  = (cmd.den != '0) && (rem_sh >= REM_W'(cmd.den));

  // Weight recurrence sum and point term rounding
  assign wsum      = wacc_r + PROD_W'(prod_r) + HALF_Q30;
  assign term_full = (prod_r + signed'(HALF_Q30)) >>> FRAC_W;
  assign term      = term_full[ACC_W-1:0];

  // Clamp to coordinate range
  always_comb begin
    if (ax_r > ACC_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      sat_x = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (ax_r < ACC_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}))) begin
      sat_x = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_x = ax_r[COORD_W-1:0];
    end
    if (ay_r > ACC_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      sat_y = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (ay_r < ACC_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}))) begin
      sat_y = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_y = ay_r[COORD_W-1:0];
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        num_r <= {cmd.j, {FRAC_W{1'b0}}} + NUM_W'(cmd.den >> 1);
        rem_r <= '0;
        w_r[0] <= WGT_W'(ONE_Q30);
        ax_r  <= '0;
        ay_r  <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= q_bit ? (rem_sh - REM_W'(cmd.den)) : rem_sh;
        num_r <= {num_r[NUM_W-2:0], q_bit};
      end
      OP_W_MUL_U: begin
        prod_r <= prod_full[PROD_W-1:0];
      end
      OP_W_MUL_T: begin
        wacc_r <= PROD_W'(prod_r);
        prod_r <= prod_full[PROD_W-1:0];
      end
      OP_W_WRITE: begin
        w_r[cmd.idx] <= wsum[FRAC_W+WGT_W-1:FRAC_W];
        prev_r       <= w_r[cmd.idx];
      end
      OP_MUL_X: begin
        prod_r <= prod_full[PROD_W-1:0];
      end
      OP_MUL_Y: begin
        ax_r   <= ax_r + term;
        prod_r <= prod_full[PROD_W-1:0];
      end
      OP_ADD_Y: begin
        ay_r <= ay_r + term;
      end
      OP_EMIT: begin
        out_x_r     <= sat_x;
        out_y_r     <= sat_y;
        out_final_r <= cmd.final_smp;
        out_trunc_r <= cmd.trunc;
      end
      default: begin
      end
    endcase
  end

  // Output request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.curve_x      = out_x_r;
  assign out_ch.curve_y      = out_y_r;
  assign out_ch.final_sample = out_final_r;
  assign out_ch.truncated    = out_trunc_r;
  assign stat.out_busy       = out_valid_r & ~out_ch.ready;
endmodule

// ===== hdl/bcs_ctrl.sv =====
module bcs_ctrl import bcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bcs_in_if.sink           in_ch,
  input  logic             cfg_we,
  input  logic [SMP_W-1:0] cfg_data,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);
  ctrl_state_t         state_r, state_nxt;
  logic [PT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SMP_W-1:0]    ns_r;
  logic [SMP_W-1:0]    s_r, s_nxt;
  logic [J_W-1:0]      j_r, j_nxt;
  logic [PT_IDX_W-1:0] d_r, d_nxt;
  logic [PT_IDX_W-1:0] i_r, i_nxt;
  logic [DCNT_W-1:0]   dc_r, dc_nxt;

  logic                full;
  logic [SMP_W-1:0]    s_eff;
  logic [PT_IDX_W-1:0] n_last;
  logic [J_W-1:0]      j_last;
  logic [PT_CNT_W-1:0] cnt_ld;

  assign full   = (cnt_r >= PT_CNT_W'(MAX_POINTS));
  assign cnt_ld = full ? cnt_r : cnt_r + 1'b1;
  assign s_eff  = (ns_r > SMP_W'(MAX_SAMPLES)) ? SMP_W'(MAX_SAMPLES) : ns_r;
  assign n_last = PT_IDX_W'(cnt_r - 1'b1);
  assign j_last = J_W'(s_r - 1'b1);

  // Hold sample count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= SMP_W'(MAX_SAMPLES);
    end else if (cfg_we) begin
      ns_r <= cfg_data;
    end
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      s_r     <= '0;
      j_r     <= '0;
      d_r     <= '0;
      i_r     <= '0;
      dc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      s_r     <= s_nxt;
      j_r     <= j_nxt;
      d_r     <= d_nxt;
      i_r     <= i_nxt;
      dc_r    <= dc_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    s_nxt         = s_r;
    j_nxt         = j_r;
    d_nxt         = d_r;
    i_nxt         = i_r;
    dc_nxt        = dc_r;
    in_ch.ready   = 1'b0;
    cmd.op        = OP_NONE;
    cmd.idx       = i_r;
    cmd.i_lt_d    = (i_r < d_r);
    cmd.i_gt0     = (i_r != '0);
    cmd.j         = j_r;
    cmd.den       = J_W'(s_r - 1'b1);
    cmd.final_smp = (j_r == j_last);
    cmd.trunc     = ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        cmd.idx     = PT_IDX_W'(cnt_r);
        if (in_ch.valid) begin
          cnt_nxt = cnt_ld;
          ovf_nxt = ovf_r | full;
          cmd.op  = full ? OP_NONE : OP_LOAD;
          if (in_ch.set_end) begin
            s_nxt = s_eff;
            j_nxt = '0;
            if (s_eff == '0) begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end else begin
              state_nxt = ST_DIV_INIT;
            end
          end
        end
      end
      ST_DIV_INIT: begin
        cmd.op    = OP_START;
        dc_nxt    = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        dc_nxt = dc_r + 1'b1;
        if (dc_r == DCNT_W'(NUM_W - 1)) begin
          i_nxt = '0;
          d_nxt = PT_IDX_W'(1);
          state_nxt = (cnt_r > PT_CNT_W'(1)) ? ST_W_MU : ST_RD;
        end
      end
      ST_W_MU: begin
        cmd.op    = OP_W_MUL_U;
        state_nxt = ST_W_MT;
      end
      ST_W_MT: begin
        cmd.op    = OP_W_MUL_T;
        state_nxt = ST_W_WR;
      end
      ST_W_WR: begin
        cmd.op = OP_W_WRITE;
        if (i_r == d_r) begin
          i_nxt = '0;
          if (d_r == n_last) begin
            state_nxt = ST_RD;
          end else begin
            d_nxt     = d_r + 1'b1;
            state_nxt = ST_W_MU;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_W_MU;
        end
      end
      ST_RD: begin
        cmd.op    = OP_RD;
        state_nxt = ST_MX;
      end
      ST_MX: begin
        cmd.op    = OP_MUL_X;
        state_nxt = ST_MY;
      end
      ST_MY: begin
        cmd.op    = OP_MUL_Y;
        state_nxt = ST_AY;
      end
      ST_AY: begin
        cmd.op = OP_ADD_Y;
        if (i_r == n_last) begin
          state_nxt = ST_EMIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op = OP_EMIT;
          if (j_r == j_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_DIV_INIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== hdl/bezier_curve_sampler.sv =====
// Channel   Dir  Payload                                         Handshake
// in_ch     in   ctrl_x, ctrl_y (Q16.16), set_end                valid/ready
// out_ch    out  curve_x, curve_y (Q16.16), final_sample, truncated  valid/ready
// cfg_*     in   cfg_data = num_samples (7 bits)                 cfg_we strobe
//
// Loading accepts one control point per cycle. After the set end, each sample
// runs a start step, a serial divide for t, the weight recurrence on one shared
// multiplier (skipped for one point), the point accumulation and an emit step.
// Reset clears the controller and empties the output register; the point
// store needs no clearing. A stalled output request holds one finished
// sample while the next is computed; the controller waits only to emit.
module bezier_curve_sampler import bcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  bcs_in_if.sink           in_ch,
  bcs_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [SMP_W-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  bcs_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .in_x   (in_ch.ctrl_x),
    .in_y   (in_ch.ctrl_y),
    .out_ch (out_ch),
    .stat   (stat)
  );
endmodule

// ===== hdl/bcs_checker.sv =====
module bcs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_set_end,
  input logic out_valid,
  input logic out_ready,
  input logic out_final
);
  // Output request stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // No loading while a non-final sample of the curve is pending
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid && !out_final))
    else $error("input open in the middle of a curve");

  // Loading continues until the set end
  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_set_end |=> in_ready)
    else $error("loading stopped before the set end");
endmodule

bind bezier_curve_sampler bcs_checker u_bcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_set_end (in_ch.set_end),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_final  (out_ch.final_sample)
);
